>>> design/lcdw_pkg.sv
// ----------------------------------------------------------------------------
// lcdw_pkg
// Shared types and constants of the LCD window write stream block.
// ----------------------------------------------------------------------------
package lcdw_pkg;

    // Input command codes.
    localparam logic CMD_OPEN_WINDOW = 1'b0;
    localparam logic CMD_PIXEL       = 1'b1;

    // Controller command bytes.
    localparam logic [7:0] DCS_COLUMN_SET   = 8'h2A;
    localparam logic [7:0] DCS_ROW_SET      = 8'h2B;
    localparam logic [7:0] DCS_MEMORY_WRITE = 8'h2C;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_OFFSET = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_OFFSET    = 2'd1;
    localparam logic [15:0] COLUMN_OFFSET_RESET = 16'd0;
    localparam logic [15:0] ROW_OFFSET_RESET    = 16'd20;

    // Default depth of the queue between front and back end.
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    typedef enum logic {
        KIND_WINDOW = 1'b0,
        KIND_PIXEL  = 1'b1
    } t_kind;

    // One classified job. For a window: a0/a1 are the column range and
    // b0/b1 the row range. For a pixel: a0 is the colour.
    typedef struct packed {
        t_kind       kind;
        logic [15:0] a0;
        logic [15:0] a1;
        logic [15:0] b0;
        logic [15:0] b1;
        logic        done;
    } t_entry;

endpackage

>>> design/lcdw_front.sv
// ----------------------------------------------------------------------------
// lcdw_front
// Accepts input items, forms window corners, tracks the pixel count.
// ----------------------------------------------------------------------------
module lcdw_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    output logic                              o_full,
    input  logic                              i_command,
    input  logic [15:0]                       i_x,
    input  logic [15:0]                       i_y,
    input  logic [15:0]                       i_width,
    input  logic [15:0]                       i_height,
    input  logic [15:0]                       i_pixel,
    input  logic                              i_cfg_we,
    input  logic [lcdw_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [lcdw_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_q_full,
    output logic                              o_q_push,
    output lcdw_pkg::t_entry                  o_q_entry
);

    logic [15:0] r_col_offset;
    logic [15:0] r_row_offset;
    logic [31:0] r_remaining;
    logic [31:0] n_remaining;

    logic        accept;
    logic        empty_window;
    logic [15:0] x0;
    logic [15:0] x1;
    logic [15:0] y0;
    logic [15:0] y1;
    logic [31:0] area;
    logic        done;

    assign o_full = i_q_full;
    assign accept = i_push && !i_q_full;

    assign empty_window = (i_width == 16'd0) || (i_height == 16'd0);
    assign x0   = i_x + r_col_offset;
    assign y0   = i_y + r_row_offset;
    assign x1   = x0 + i_width - 16'd1;
    assign y1   = y0 + i_height - 16'd1;
    assign area = {16'd0, i_width} * {16'd0, i_height};
    assign done = (r_remaining == 32'd1);

    always_comb begin
        n_remaining = r_remaining;
        o_q_push    = 1'b0;
        o_q_entry   = '0;
        if (i_command == lcdw_pkg::CMD_OPEN_WINDOW) begin
            o_q_entry.kind = lcdw_pkg::KIND_WINDOW;
            o_q_entry.a0   = x0;
            o_q_entry.a1   = x1;
            o_q_entry.b0   = y0;
            o_q_entry.b1   = y1;
            if (accept && !empty_window) begin
                o_q_push    = 1'b1;
                n_remaining = area;
            end
        end else begin
            o_q_entry.kind = lcdw_pkg::KIND_PIXEL;
            o_q_entry.a0   = i_pixel;
            o_q_entry.done = done;
            if (accept) begin
                o_q_push = 1'b1;
                if (r_remaining != 32'd0) begin
                    n_remaining = r_remaining - 32'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_offset <= lcdw_pkg::COLUMN_OFFSET_RESET;
            r_row_offset <= lcdw_pkg::ROW_OFFSET_RESET;
            r_remaining  <= 32'd0;
        end else begin
            r_remaining <= n_remaining;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    lcdw_pkg::REG_COLUMN_OFFSET: r_col_offset <= i_cfg_data;
                    lcdw_pkg::REG_ROW_OFFSET:    r_row_offset <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // A pixel flagged as finishing the window must leave the count at zero.
    a_done_empties_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_push && o_q_entry.kind == lcdw_pkg::KIND_PIXEL && o_q_entry.done)
        |=> (r_remaining == 32'd0))
        else $error("window_done issued but pixel count not zero");

endmodule

>>> design/lcdw_queue.sv
// ----------------------------------------------------------------------------
// lcdw_queue
// Small first-in first-out queue of classified jobs.
// ----------------------------------------------------------------------------
module lcdw_queue #(
    parameter int DEPTH = lcdw_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  lcdw_pkg::t_entry i_entry,
    output logic             o_full,
    input  logic             i_pop,
    output lcdw_pkg::t_entry o_entry,
    output logic             o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    lcdw_pkg::t_entry r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_entry = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_ONE;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_ONE;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_ONE;
                2'b01:   r_count <= r_count - CNT_ONE;
                default: ;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != FULL_CNT))
        else $error("job queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("job queue read while empty");

endmodule

>>> design/lcdw_back.sv
// ----------------------------------------------------------------------------
// lcdw_back
// Serializes queued jobs into link bytes behind an output register.
// ----------------------------------------------------------------------------
module lcdw_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lcdw_pkg::t_entry i_q_entry,
    input  logic             i_q_empty,
    output logic             o_q_pop,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [7:0]       o_out_byte,
    output logic             o_is_data,
    output logic             o_last,
    output logic             o_window_done
);

    localparam logic [3:0] WINDOW_LAST_IDX = 4'd10;
    localparam logic [3:0] PIXEL_LAST_IDX  = 4'd1;

    lcdw_pkg::t_entry r_cur;
    logic             r_cur_valid;
    logic [3:0]       r_idx;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_data;
    logic             r_out_last;
    logic             r_out_done;

    logic       advance;
    logic       at_last;
    logic       take_head;
    logic [7:0] sel_byte;
    logic       sel_data;

    assign advance   = !r_out_valid || i_pop;
    assign at_last   = (r_cur.kind == lcdw_pkg::KIND_PIXEL) ? (r_idx == PIXEL_LAST_IDX)
                                                          : (r_idx == WINDOW_LAST_IDX);
    assign take_head = !i_q_empty && (!r_cur_valid || (advance && at_last));
    assign o_q_pop   = take_head;

    always_comb begin
        sel_byte = 8'h00;
        sel_data = 1'b1;
        if (r_cur.kind == lcdw_pkg::KIND_PIXEL) begin
            sel_byte = (r_idx == 4'd0) ? r_cur.a0[15:8] : r_cur.a0[7:0];
        end else begin
            case (r_idx)
                4'd0: begin
                    sel_byte = lcdw_pkg::DCS_COLUMN_SET;
                    sel_data = 1'b0;
                end
                4'd1: sel_byte = r_cur.a0[15:8];
                4'd2: sel_byte = r_cur.a0[7:0];
                4'd3: sel_byte = r_cur.a1[15:8];
                4'd4: sel_byte = r_cur.a1[7:0];
                4'd5: begin
                    sel_byte = lcdw_pkg::DCS_ROW_SET;
                    sel_data = 1'b0;
                end
                4'd6: sel_byte = r_cur.b0[15:8];
                4'd7: sel_byte = r_cur.b0[7:0];
                4'd8: sel_byte = r_cur.b1[15:8];
                4'd9: sel_byte = r_cur.b1[7:0];
                default: begin
                    sel_byte = lcdw_pkg::DCS_MEMORY_WRITE;
                    sel_data = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_head) begin
            r_cur <= i_q_entry;
        end
        if (advance) begin
            r_out_byte <= sel_byte;
            r_out_data <= sel_data;
            r_out_last <= at_last;
            r_out_done <= at_last && r_cur.done && (r_cur.kind == lcdw_pkg::KIND_PIXEL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_idx       <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= r_cur_valid;
            end
            if (take_head) begin
                r_cur_valid <= 1'b1;
                r_idx       <= 4'd0;
            end else if (advance && r_cur_valid) begin
                if (at_last) begin
                    r_cur_valid <= 1'b0;
                end else begin
                    r_idx <= r_idx + 4'd1;
                end
            end
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_is_data     = r_out_data;
    assign o_last        = r_out_last;
    assign o_window_done = r_out_done;

    a_done_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_done) |-> (r_out_last && r_out_data))
        else $error("window_done on a byte that does not end a pixel");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_valid |-> (r_idx <= WINDOW_LAST_IDX))
        else $error("byte index ran past the end of the job");

endmodule

>>> design/lcd_window_write_stream.sv
// ----------------------------------------------------------------------------
// lcd_window_write_stream
// Window and pixel items in, command/data byte stream for a serial LCD out.
// ----------------------------------------------------------------------------
// Each transfer on the input side produces its bytes on the output queue in
// order. An open-window item produces eleven bytes (column set with start and
// end column, row set with start and end row, then memory write), or none at
// all when its width or height is zero. A pixel item produces two data bytes,
// high byte first. One byte leaves per cycle while the output is popped and a
// job is waiting; the pace is set by the byte serializer in the back end. The
// front end takes an item in every cycle while the job queue between the two
// halves has room, so a short burst of items is absorbed while bytes are still
// going out. From an idle block, an item passes the job queue, the current-job
// register and the output register before its first byte shows on the
// output. The column and row offsets may only be written while the block is
// idle; they are applied when an open-window item is accepted.
// ----------------------------------------------------------------------------
module lcd_window_write_stream #(
    parameter int QUEUE_DEPTH = lcdw_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input item queue side.
    input  logic                              push,
    output logic                              full,
    input  logic                              i_command,
    input  logic [15:0]                       i_x,
    input  logic [15:0]                       i_y,
    input  logic [15:0]                       i_width,
    input  logic [15:0]                       i_height,
    input  logic [15:0]                       i_pixel,
    // Configuration write port.
    input  logic                              i_cfg_we,
    input  logic [lcdw_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [lcdw_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Output byte queue side.
    output logic                              empty,
    input  logic                              pop,
    output logic [7:0]                        o_out_byte,
    output logic                              o_is_data,
    output logic                              o_last,
    output logic                              o_window_done
);

    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    lcdw_pkg::t_entry q_wr_entry;
    lcdw_pkg::t_entry q_rd_entry;
    logic             out_empty;

    // The front end classifies each item and keeps the pixel count, so the
    // count follows input order regardless of how far the back end lags.
    lcdw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_command   (i_command),
        .i_x         (i_x),
        .i_y         (i_y),
        .i_width     (i_width),
        .i_height    (i_height),
        .i_pixel     (i_pixel),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_entry   (q_wr_entry)
    );

    // The job queue lets the front keep taking items while the back end is
    // still busy shifting out the bytes of earlier jobs.
    lcdw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_wr_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_entry (q_rd_entry),
        .o_empty (q_empty)
    );

    // The back end walks each job byte by byte into a registered output, and
    // fetches the next job in the same cycle as the last byte of the current
    // one, so consecutive jobs leave without a gap.
    lcdw_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_entry     (q_rd_entry),
        .i_q_empty     (q_empty),
        .o_q_pop       (q_pop),
        .i_pop         (pop && !out_empty),
        .o_empty       (out_empty),
        .o_out_byte    (o_out_byte),
        .o_is_data     (o_is_data),
        .o_last        (o_last),
        .o_window_done (o_window_done)
    );

    assign empty = out_empty;

endmodule
